@@ hw/rtl/handle_table_macros.svh @@
// Assertion macros shared by the handle table RTL.
`ifndef HANDLE_TABLE_MACROS_SVH
`define HANDLE_TABLE_MACROS_SVH

// Checks a property on every rising edge of clk while arst_n is high.
`define HT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising edge of clk.
`define HT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/ht_pkg.sv @@
// Package with the constants and control types of the handle table.
package ht_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;

	localparam logic [31:0] FIRST_HANDLE = 32'h0000_1000;
	localparam logic [31:0] LAST_HANDLE  = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLOSE  = 2'd2;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic finish;
		logic emit;
	} ht_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic skip;
		logic hit;
		logic scan_end;
		logic out_free;
	} ht_sts_t;

endpackage

@@ hw/rtl/ht_ctrl.sv @@
// Controller state machine of the handle table.
module ht_ctrl import ht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  ht_sts_t sts,
	output ht_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = s_tvalid;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.finish = sts.skip || sts.hit || sts.scan_end;
			end
			ST_DONE: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.finish) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/ht_dpath.sv @@
// Datapath of the handle table: slot memories, scan counter, handle counter and output register.
module ht_dpath import ht_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [103:0]   s_tdata,
	input  logic [1:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [103:0]   m_tdata,
	output logic           m_tuser,
	input  ht_cmd_t        cmd,
	output ht_sts_t        sts
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] LAST_C  = CW'(TABLE_DEPTH - 1);

	logic [31:0] handle_mem [TABLE_DEPTH];
	logic [7:0]  type_mem   [TABLE_DEPTH];
	logic [63:0] ref_mem    [TABLE_DEPTH];

	logic [1:0]    op_q;
	logic [31:0]   key_q;
	logic [7:0]    type_q;
	logic [63:0]   ref_q;
	logic [CW-1:0] addr_q;
	logic [31:0]   next_handle_q;

	logic          rd_vld_s1;
	logic [AW-1:0] addr_s1;
	logic [31:0]   rd_handle_s1;
	logic [7:0]    rd_type_s1;
	logic [63:0]   rd_ref_s1;

	logic          res_found_q;
	logic [31:0]   res_handle_q;
	logic [7:0]    res_type_q;
	logic [63:0]   res_ref_q;

	logic          out_vld_q;
	logic          out_found_q;
	logic [103:0]  out_data_q;

	logic          is_create;
	logic          is_lookup;
	logic          is_close;
	logic          scan_valid;
	logic [31:0]   key_eff;
	logic          hit;
	logic          commit;
	logic          hwr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_handle;

	assign is_create  = (op_q == OP_CREATE);
	assign is_lookup  = (op_q == OP_LOOKUP);
	assign is_close   = (op_q == OP_CLOSE);
	assign scan_valid = (addr_q < DEPTH_C);
	assign key_eff    = is_create ? 32'd0 : key_q;
	assign hit        = rd_vld_s1 && (rd_handle_s1 == key_eff);
	assign commit     = cmd.finish && hit;

	assign hwr_en    = cmd.clear || (commit && (is_create || is_close));
	assign wr_addr   = cmd.clear ? addr_q[AW-1:0] : addr_s1;
	assign wr_handle = (!cmd.clear && is_create) ? next_handle_q : 32'd0;

	assign sts.clear_last = (addr_q == LAST_C);
	assign sts.skip       = (is_lookup || is_close) ? (key_q == 32'd0) : !is_create;
	assign sts.hit        = hit;
	assign sts.scan_end   = !rd_vld_s1 && !scan_valid;
	assign sts.out_free   = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (hwr_en) handle_mem[wr_addr] <= wr_handle;
		if (cmd.scan && scan_valid) rd_handle_s1 <= handle_mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (commit && is_create) type_mem[addr_s1] <= type_q;
		if (cmd.scan && scan_valid) rd_type_s1 <= type_mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (commit && is_create) ref_mem[addr_s1] <= ref_q;
		if (cmd.scan && scan_valid) rd_ref_s1 <= ref_mem[addr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			rd_vld_s1     <= 1'b0;
			next_handle_q <= FIRST_HANDLE;
			out_vld_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.clear || (cmd.scan && scan_valid)) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.load) begin
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= scan_valid;
			end
			if (commit && is_create) begin
				next_handle_q <= (next_handle_q == LAST_HANDLE) ? FIRST_HANDLE :
					next_handle_q + 32'd1;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[31:0];
			type_q <= s_tdata[39:32];
			ref_q  <= s_tdata[103:40];
		end
		if (cmd.scan) addr_s1 <= addr_q[AW-1:0];
		if (cmd.finish) begin
			res_found_q  <= hit;
			res_handle_q <= (hit && is_create) ? next_handle_q : 32'd0;
			res_type_q   <= (hit && is_lookup) ? rd_type_s1 : 8'd0;
			res_ref_q    <= (hit && is_lookup) ? rd_ref_s1 : 64'd0;
		end
		if (cmd.emit) begin
			out_found_q <= res_found_q;
			out_data_q  <= {res_ref_q, res_type_q, res_handle_q};
		end
	end

endmodule

@@ hw/rtl/handle_table.sv @@
// Top level of the handle table: create, lookup and close of numbered handles.
//
//   Channel  Dir  Payload
//   s_*      in   tuser: op; tdata: handle, obj_type, obj_ref
//   m_*      out  tuser: found; tdata: handle_out, obj_type_out, obj_ref_out
//
// Each transaction scans the slot memory one slot per cycle from slot zero, so the time between
// acceptances is set by how far the scan has to run.
// After reset a clearing pass frees all slots; s_tready is low then.
// One item is in work at a time; a finished result waits in the output register, and a
// stalled m_tready holds the next result back until that register frees up.
`include "handle_table_macros.svh"

module handle_table import ht_pkg::*; #(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // handle[31:0], obj_type[39:32], obj_ref[103:40]
	input  logic [1:0]   s_tuser,   // op[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // handle_out[31:0], obj_type_out[39:32], obj_ref_out[103:40]
	output logic         m_tuser    // found[0]
);

	ht_cmd_t cmd;
	ht_sts_t sts;

	ht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ht_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

	`HT_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "input taken while busy")
	`HT_ASSERT(a_miss_is_zero, (m_tvalid && !m_tuser) |-> (m_tdata == 104'd0), "miss with data")
	`HT_NEVER(a_handle_range, m_tvalid && (m_tdata[31:0] != 32'd0) && (m_tdata[31:0] < FIRST_HANDLE), "handle below first number")

endmodule

@@ bench/handle_table_tb.sv @@
// Self-checking testbench for the handle table: directed and random create, lookup, close and no-op traffic.
module handle_table_tb;
	import ht_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = DEPTH + 50;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] handle;
		logic [7:0]  otype;
		logic [63:0] oref;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [31:0] handle;
		logic [7:0]  otype;
		logic [63:0] oref;
	} reply_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         m_tuser;

	request_t offered = '0;
	request_t op_queue[$];
	reply_t   due_replies[$];
	reply_t   want;
	logic     s_taken = 1'b0;
	logic     hold_done = 1'b0;
	int       hold_left = 0;
	int       replies_seen = 0;
	int       cycles = 0;
	int       errors = 0;
	int       creates_queued = 0;
	logic     calm;

	logic [31:0] tbl_handle [DEPTH];
	logic [7:0]  tbl_type [DEPTH];
	logic [63:0] tbl_ref [DEPTH];
	logic [31:0] next_num;

	assign s_tuser = offered.op;
	assign s_tdata = {offered.oref, offered.otype, offered.handle};
	assign calm = cycles >= 40000 && cycles < 90000;

	handle_table #(.TABLE_DEPTH(DEPTH)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic int find_slot(input logic [31:0] key);
		int i;
		for (i = 0; i < DEPTH; i++) begin
			if (tbl_handle[i] == key) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic reply_t table_apply(input request_t rq);
		int slot;
		reply_t rp;
		rp = '0;
		slot = -1;
		case (rq.op)
			OP_CREATE: begin
				slot = find_slot(32'd0);
				if (slot >= 0) begin
					tbl_handle[slot] = next_num;
					tbl_type[slot] = rq.otype;
					tbl_ref[slot] = rq.oref;
					rp.found = 1'b1;
					rp.handle = next_num;
					next_num = (next_num == LAST_HANDLE) ? FIRST_HANDLE : next_num + 32'd1;
				end
			end
			OP_LOOKUP: begin
				if (rq.handle != 32'd0) begin
					slot = find_slot(rq.handle);
				end
				if (slot >= 0) begin
					rp.found = 1'b1;
					rp.otype = tbl_type[slot];
					rp.oref = tbl_ref[slot];
				end
			end
			OP_CLOSE: begin
				if (rq.handle != 32'd0) begin
					slot = find_slot(rq.handle);
				end
				if (slot >= 0) begin
					tbl_handle[slot] = '0;
					tbl_type[slot] = '0;
					tbl_ref[slot] = '0;
					rp.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return rp;
	endfunction

	task automatic push_req(input logic [1:0] op, input logic [31:0] h, input logic [7:0] t,
			input logic [63:0] r);
		op_queue.push_back({op, h, t, r});
		if (op == OP_CREATE) begin
			creates_queued++;
		end
	endtask

	// Mostly handles that were or may have been handed out, some noise and some zero.
	function automatic logic [31:0] pick_handle();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			return 32'd0;
		end
		if (roll < 15) begin
			return $urandom;
		end
		return FIRST_HANDLE + $urandom_range(0, creates_queued + 8);
	endfunction

	task automatic push_random();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			push_req(OP_CREATE, $urandom, 8'($urandom), {$urandom, $urandom});
		end else if (roll < 60) begin
			push_req(OP_LOOKUP, pick_handle(), 8'($urandom), {$urandom, $urandom});
		end else if (roll < 92) begin
			push_req(OP_CLOSE, pick_handle(), 8'($urandom), {$urandom, $urandom});
		end else begin
			push_req(OP_NOP, $urandom, 8'($urandom), {$urandom, $urandom});
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		s_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			due_replies.push_back(table_apply(offered));
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_taken) begin
			if (op_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
				offered <= op_queue.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The long hold-off lets the block fill its output register and stall its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && replies_seen >= 150) begin
			hold_left <= 600;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(0, 99) >= 20;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			replies_seen <= replies_seen + 1;
			if (due_replies.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got found %0d data %0h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = due_replies.pop_front();
				check_field("found", 64'(want.found), 64'(m_tuser));
				check_field("handle_out", 64'(want.handle), 64'(m_tdata[31:0]));
				check_field("obj_type_out", 64'(want.otype), 64'(m_tdata[39:32]));
				check_field("obj_ref_out", want.oref, m_tdata[103:40]);
			end
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < DEPTH; i++) begin
			tbl_handle[i] = '0;
			tbl_type[i] = '0;
			tbl_ref[i] = '0;
		end
		next_num = FIRST_HANDLE;

		push_req(OP_CREATE, 32'd0, 8'h00, 64'd0);
		push_req(OP_CREATE, 32'hFFFF_FFFF, 8'hFF, '1);
		push_req(OP_CREATE, $urandom, 8'($urandom), {$urandom, $urandom});
		push_req(OP_LOOKUP, FIRST_HANDLE, 8'h00, 64'd0);
		push_req(OP_LOOKUP, FIRST_HANDLE + 1, 8'hFF, '1);
		push_req(OP_LOOKUP, FIRST_HANDLE + 2, 8'($urandom), {$urandom, $urandom});
		push_req(OP_LOOKUP, 32'd0, 8'h00, 64'd0);
		push_req(OP_CLOSE, 32'd0, 8'h00, 64'd0);
		push_req(OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 64'd0);
		push_req(OP_CLOSE, FIRST_HANDLE - 1, 8'h00, 64'd0);
		push_req(OP_NOP, 32'hFFFF_FFFF, 8'hFF, '1);
		push_req(OP_CLOSE, FIRST_HANDLE + 1, 8'h00, 64'd0);
		push_req(OP_LOOKUP, FIRST_HANDLE + 1, 8'h00, 64'd0);
		push_req(OP_CLOSE, FIRST_HANDLE + 1, 8'h00, 64'd0);
		push_req(OP_CREATE, $urandom, 8'($urandom), {$urandom, $urandom});
		push_req(OP_LOOKUP, FIRST_HANDLE + 3, 8'h00, 64'd0);
		push_req(OP_CLOSE, FIRST_HANDLE, 8'h00, 64'd0);
		push_req(OP_CLOSE, FIRST_HANDLE + 2, 8'h00, 64'd0);
		push_req(OP_CLOSE, FIRST_HANDLE + 3, 8'h00, 64'd0);
		push_req(OP_LOOKUP, FIRST_HANDLE + 3, 8'h00, 64'd0);
		push_req(OP_CREATE, $urandom, 8'($urandom), {$urandom, $urandom});

		// Enough creates to fill every slot and then be refused.
		for (i = 0; i < 280; i++) begin
			push_req(OP_CREATE, $urandom, 8'($urandom), {$urandom, $urandom});
		end
		for (i = 0; i < 500; i++) begin
			push_random();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (op_queue.size() != 0 || s_tvalid) begin
			@(posedge clk);
		end
		while (due_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
